// ===== design/fwt_pkg.sv =====
// shared types, constants and byte-class functions for the field word tokenizer
// no dependencies
`timescale 1ns / 1ps

package fwt_pkg;

    localparam int DEFAULT_MAX_WORD_LEN = 31;
    localparam int CHAR_W               = 8;
    localparam int INDEX_W              = 32;

    localparam logic [CHAR_W-1:0]  CH_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0]  CH_DASH    = 8'h2D;
    localparam logic [CHAR_W-1:0]  CH_NEWLINE = 8'h0A;
    localparam logic [INDEX_W-1:0] INDEX_ONE  = 32'd1;
    localparam logic [INDEX_W-1:0] INDEX_MAX  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic               valid;
        logic               field;
        logic [INDEX_W-1:0] index;
    } emit_req_t;

    function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
        is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                   (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_word_char(input logic [CHAR_W-1:0] c);
        is_word_char = is_alnum(c) || (c == CH_DOT) || (c == CH_DASH);
    endfunction

    function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
        to_lower = (c >= 8'h41 && c <= 8'h5A) ? (c + 8'h20) : c;
    endfunction

endpackage

// ===== design/fwt_if.sv =====
// word channel interfaces: document bytes in, word characters out
// depends on fwt_pkg
`timescale 1ns / 1ps

interface fwt_text_if
    import fwt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_byte;
    logic              doc_final;

    modport source (output valid, output text_byte, output doc_final, input ready);
    modport sink   (input valid, input text_byte, input doc_final, output ready);
endinterface

interface fwt_word_if
    import fwt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  word_char;
    logic               is_field_name;
    logic [INDEX_W-1:0] word_index;
    logic               word_last;

    modport source (output valid, output word_char, output is_field_name,
                    output word_index, output word_last, input ready);
    modport sink   (input valid, input word_char, input is_field_name,
                    input word_index, input word_last, output ready);
endinterface

// ===== design/fwt_word_ram.sv =====
// word store: one write port, one read port with registered read data
// depends on fwt_pkg
`timescale 1ns / 1ps

module fwt_word_ram
    import fwt_pkg::*;
#(
    parameter int DEPTH = DEFAULT_MAX_WORD_LEN
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [CHAR_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [CHAR_W-1:0]        rdata
);

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/fwt_scan.sv =====
// byte scanner: word boundaries, field detection, word numbering, store writes
// depends on fwt_pkg
`timescale 1ns / 1ps

module fwt_scan
    import fwt_pkg::*;
#(
    parameter int MAX_WORD_LEN = DEFAULT_MAX_WORD_LEN,
    localparam int AW = $clog2(MAX_WORD_LEN),
    localparam int LW = $clog2(MAX_WORD_LEN + 1)
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [CHAR_W-1:0] text_byte,
    input  logic              doc_final,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [CHAR_W-1:0] wr_data,
    output emit_req_t         emit,
    output logic [LW-1:0]     emit_len
);

    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_WORD_LEN);
    localparam logic [LW-1:0] LEN_ONE = LW'(1);

    logic               in_word_reg, in_word_next;
    logic               skip_reg, skip_next;
    logic               newline_reg, newline_next;
    logic               field_reg, field_next;
    logic               dot_reg, dot_next;
    logic [LW-1:0]      len_reg, len_next;
    logic [INDEX_W-1:0] count_reg, count_next;

    logic          alnum, word_ch, nl;
    logic [LW-1:0] base_len;
    logic          base_dot;

    assign alnum   = is_alnum(text_byte);
    assign word_ch = is_word_char(text_byte);
    assign nl      = (text_byte == CH_NEWLINE);

    always_comb
    begin
        in_word_next = in_word_reg;
        skip_next    = skip_reg;
        newline_next = newline_reg;
        field_next   = field_reg;
        dot_next     = dot_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        wr_en        = 1'b0;
        wr_addr      = len_reg[AW-1:0];
        wr_data      = text_byte;
        emit.valid   = 1'b0;
        base_len     = len_reg;
        base_dot     = dot_reg;
        if (accept)
        begin
            if (in_word_reg)
            begin
                if (word_ch)
                begin
                    if (len_reg < MAX_LEN && !skip_reg)
                    begin
                        wr_en    = 1'b1;
                        len_next = len_reg + LEN_ONE;
                        dot_next = (text_byte == CH_DOT);
                    end
                    else
                    begin
                        skip_next = 1'b1;
                    end
                end
                else
                begin
                    emit.valid   = 1'b1;
                    in_word_next = 1'b0;
                    skip_next    = 1'b0;
                    len_next     = '0;
                    newline_next = nl;
                end
            end
            else if (alnum)
            begin
                wr_en        = 1'b1;
                wr_addr      = '0;
                len_next     = LEN_ONE;
                in_word_next = 1'b1;
                skip_next    = 1'b0;
                field_next   = newline_reg;
                dot_next     = 1'b0;
            end
            else
            begin
                newline_next = nl;
            end

            if (doc_final)
            begin
                if (in_word_next)
                begin
                    emit.valid = 1'b1;
                    base_len   = len_next;
                    base_dot   = dot_next;
                end
                in_word_next = 1'b0;
                skip_next    = 1'b0;
                len_next     = '0;
                newline_next = 1'b1;
            end

            if (emit.valid && !field_next && count_reg != INDEX_MAX)
            begin
                count_next = count_reg + INDEX_ONE;
            end
            if (doc_final)
            begin
                count_next = INDEX_ONE;
            end
        end
        emit.field = field_next;
        emit.index = count_reg;
        emit_len   = (base_len > LEN_ONE && base_dot) ? (base_len - LEN_ONE) : base_len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word_reg <= 1'b0;
            skip_reg    <= 1'b0;
            newline_reg <= 1'b1;
            field_reg   <= 1'b0;
            dot_reg     <= 1'b0;
            len_reg     <= '0;
            count_reg   <= INDEX_ONE;
        end
        else
        begin
            in_word_reg <= in_word_next;
            skip_reg    <= skip_next;
            newline_reg <= newline_next;
            field_reg   <= field_next;
            dot_reg     <= dot_next;
            len_reg     <= len_next;
            count_reg   <= count_next;
        end
    end

endmodule

// ===== design/fwt_emit.sv =====
// word emitter: reads the word store in order and drives the output register
// depends on fwt_pkg, fwt_if
`timescale 1ns / 1ps

module fwt_emit
    import fwt_pkg::*;
#(
    parameter int MAX_WORD_LEN = DEFAULT_MAX_WORD_LEN,
    localparam int AW = $clog2(MAX_WORD_LEN),
    localparam int LW = $clog2(MAX_WORD_LEN + 1)
)(
    input  logic              clk,
    input  logic              rst_n,
    input  emit_req_t         start,
    input  logic [LW-1:0]     start_len,
    output logic              busy,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr,
    input  logic [CHAR_W-1:0] rd_data,
    fwt_word_if.source        words
);

    localparam logic [LW-1:0] LEN_ONE = LW'(1);

    logic               busy_reg;
    logic [LW-1:0]      ptr_reg;
    logic [LW-1:0]      len_reg;
    logic               field_reg;
    logic [INDEX_W-1:0] index_reg;

    logic               s1_valid_reg;
    logic               s1_last_reg;
    logic               s1_field_reg;
    logic [INDEX_W-1:0] s1_index_reg;

    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_field_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic               out_last_reg;

    logic advance, last_issue;

    assign advance    = !out_valid_reg || words.ready;
    assign rd_en      = busy_reg && (!s1_valid_reg || advance);
    assign rd_addr    = ptr_reg[AW-1:0];
    assign last_issue = (ptr_reg == len_reg - LEN_ONE);
    assign busy       = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (start.valid && !busy_reg)
            begin
                busy_reg <= 1'b1;
            end
            else if (rd_en && last_issue)
            begin
                busy_reg <= 1'b0;
            end

            if (rd_en)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (start.valid && !busy_reg)
        begin
            ptr_reg   <= '0;
            len_reg   <= start_len;
            field_reg <= start.field;
            index_reg <= start.field ? '0 : start.index;
        end
        else if (rd_en)
        begin
            ptr_reg <= ptr_reg + LEN_ONE;
        end

        if (rd_en)
        begin
            s1_last_reg  <= last_issue;
            s1_field_reg <= field_reg;
            s1_index_reg <= index_reg;
        end

        if (advance && s1_valid_reg)
        begin
            out_char_reg  <= s1_field_reg ? rd_data : to_lower(rd_data);
            out_field_reg <= s1_field_reg;
            out_index_reg <= s1_index_reg;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign words.valid         = out_valid_reg;
    assign words.word_char     = out_char_reg;
    assign words.is_field_name = out_field_reg;
    assign words.word_index    = out_index_reg;
    assign words.word_last     = out_last_reg;

endmodule

// ===== design/field_word_tokenizer_core.sv =====
// field word tokenizer top level: scanner, word store and emitter
// depends on fwt_pkg, fwt_if, fwt_word_ram, fwt_scan, fwt_emit
`timescale 1ns / 1ps

// Takes one document byte per cycle on text while the emitter is idle and
// returns words one character at a time on words, each tagged as field name
// or numbered indexable word, with word_last on its final character. A byte
// that closes a word (or a final byte inside one) starts the emitter, and
// text is held while the emitter reads the word out of the store: the word
// store has a single read port, read one address a cycle unless the words
// channel stalls. The last characters drain through the output register
// while the next bytes are already taken.
module field_word_tokenizer_core
    import fwt_pkg::*;
#(
    parameter int MAX_WORD_LEN = DEFAULT_MAX_WORD_LEN
)(
    input  logic       clk,
    input  logic       rst_n,
    fwt_text_if.sink   text,
    fwt_word_if.source words
);

    localparam int AW = $clog2(MAX_WORD_LEN);
    localparam int LW = $clog2(MAX_WORD_LEN + 1);

    logic              accept;
    logic              busy;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CHAR_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [CHAR_W-1:0] rd_data;
    emit_req_t         emit;
    logic [LW-1:0]     emit_len;

    assign text.ready = !busy;
    assign accept     = text.valid && !busy;

    fwt_scan #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (text.text_byte),
        .doc_final (text.doc_final),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .emit      (emit),
        .emit_len  (emit_len)
    );

    fwt_word_ram #(
        .DEPTH (MAX_WORD_LEN)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    fwt_emit #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (emit),
        .start_len (emit_len),
        .busy      (busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .words     (words)
    );

endmodule
